/* rtl/core/dcxm_pkg.sv */
// Types and constants shared by the dual counter XOR modulator files.
package dcxm_pkg;

    localparam int unsigned GAIN_W   = 11;
    localparam int unsigned SUM_W    = 13;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned LEVEL_W  = 17;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = 11'd1280;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 11'd256;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF   = 3'd4;

    typedef struct packed {
        logic gate_a;
        logic gate_a_present;
        logic advance_a;
        logic gate_b;
        logic gate_b_present;
        logic advance_b;
    } item_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] smoothed_level;
        logic               gate_out;
        logic               gate2_out;
        logic [CNT_W-1:0]   pattern;
    } result_word_t;

endpackage

/* rtl/core/dcxm_arith.sv */
// Sequenced shared-adder unit: restoring divide for the level, serial multiply for the smoother.
module dcxm_arith
    import dcxm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     raw,
    input  logic [SUM_W-1:0]     total,
    input  logic [COEF_W-1:0]    alpha,
    input  logic [LEVEL_W-1:0]   prev,
    input  logic                 take,
    output logic                 idle,
    output logic                 done,
    output logic [LEVEL_W-1:0]   level,
    output logic [LEVEL_W-1:0]   smoothed
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_DIFF = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    localparam int unsigned ADD_W = 19;
    localparam int unsigned REM_W = SUM_W + 1;
    localparam int unsigned DIF_W = LEVEL_W + 1;
    localparam logic [4:0]  DIV_LAST = 5'd16;
    localparam logic [4:0]  MUL_LAST = 5'd15;

    state_t                    state_reg, state_next;
    logic [4:0]                step_reg, step_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [SUM_W-1:0]          total_reg, total_next;
    logic [LEVEL_W-1:0]        quo_reg, quo_next;
    logic [COEF_W-1:0]         alpha_reg, alpha_next;
    logic [LEVEL_W-1:0]        prev_reg, prev_next;
    logic signed [DIF_W-1:0]   diff_reg, diff_next;
    logic signed [DIF_W-1:0]   hacc_reg, hacc_next;
    logic [LEVEL_W-1:0]        smoothed_reg, smoothed_next;

    logic [REM_W-1:0]          trial;
    logic signed [ADD_W-1:0]   add_a, add_b, add_sum;
    logic                      add_sub;

    // the one adder/subtractor
    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(ADD_W-1){1'b0}}, add_sub};

    assign trial = (step_reg == 5'd0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_DIV:
            begin
                add_a   = {{(ADD_W-REM_W){1'b0}}, trial};
                add_b   = {{(ADD_W-SUM_W){1'b0}}, total_reg};
                add_sub = 1'b1;
            end
            ST_DIFF:
            begin
                add_a   = {{(ADD_W-LEVEL_W){1'b0}}, prev_reg};
                add_b   = {{(ADD_W-LEVEL_W){1'b0}}, quo_reg};
                add_sub = 1'b1;
            end
            ST_MUL:
            begin
                add_a = {hacc_reg[DIF_W-1], hacc_reg};
                add_b = alpha_reg[0] ? {diff_reg[DIF_W-1], diff_reg} : '0;
            end
            ST_FIN:
            begin
                add_a = {{(ADD_W-LEVEL_W){1'b0}}, quo_reg};
                add_b = {hacc_reg[DIF_W-1], hacc_reg};
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        total_next    = total_reg;
        quo_next      = quo_reg;
        alpha_next    = alpha_reg;
        prev_next     = prev_reg;
        diff_next     = diff_reg;
        hacc_next     = hacc_reg;
        smoothed_next = smoothed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = {1'b0, raw};
                    total_next = total;
                    alpha_next = alpha;
                    prev_next  = prev;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = (total == '0) ? ST_DIFF : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!add_sum[ADD_W-1])
                begin
                    rem_next = add_sum[REM_W-1:0];
                    quo_next = {quo_reg[LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[LEVEL_W-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                // smoother - level; then smoother' = level + floor(alpha * diff / 2^16)
                diff_next  = add_sum[DIF_W-1:0];
                hacc_next  = '0;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                hacc_next  = add_sum[ADD_W-1:1];
                alpha_next = {1'b0, alpha_reg[COEF_W-1:1]};
                step_next  = step_reg + 5'd1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                smoothed_next = add_sum[LEVEL_W-1:0];
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        total_reg    <= total_next;
        quo_reg      <= quo_next;
        alpha_reg    <= alpha_next;
        prev_reg     <= prev_next;
        diff_reg     <= diff_next;
        hacc_reg     <= hacc_next;
        smoothed_reg <= smoothed_next;
    end

    assign idle     = (state_reg == ST_IDLE);
    assign done     = (state_reg == ST_DONE);
    assign level    = quo_reg;
    assign smoothed = smoothed_reg;

endmodule

/* rtl/core/dual_counter_xor_modulator.sv */
// Top level of the dual counter XOR modulator.
//
// Usage:
//   item channel (item_valid/item_ready/item): one word per tick carrying the two
//   gate levels, their present flags and the forced-advance flags.
//   result channel (result_valid/result_ready/result): one word per item with the
//   level, smoothed level, two gate bits and the 4-bit pattern.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; indexes
//   0..3 write gain_0..gain_3 (saturated at 1280), 4 writes the smoothing
//   coefficient, other indexes are ignored. Write only while idle.
// Timing:
//   The counters and pattern update at the accepting edge; the shared adder then
//   runs a 17-step restoring divide, one difference step, a 16-step serial
//   multiply and one final add (zero total gain skips the divide), and the result
//   is then registered in the output register. A new word is taken only after the
//   previous one has left the arithmetic unit; item_ready is low while the adder
//   sequence runs.
// Reset: counters, gate history and smoother clear, gains go to 256, coefficient 0.
// Stall: the output register holds one finished word; a second finished word waits
//   in the arithmetic unit, and no new word is taken until it moves on.
module dual_counter_xor_modulator
    import dcxm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_word_t            item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_word_t          result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_data
);

    logic [GAIN_W-1:0]   gain_reg [4];
    logic [COEF_W-1:0]   coef_reg;
    logic [CNT_W-1:0]    count_a_reg, count_a_next;
    logic [CNT_W-1:0]    count_b_reg, count_b_next;
    logic                last_a_reg, last_a_next;
    logic                last_b_reg, last_b_next;
    logic [LEVEL_W-1:0]  smoother_reg;
    logic [CNT_W-1:0]    pattern_reg;
    logic                result_valid_reg;
    result_word_t        result_reg;

    logic [CNT_W-1:0]    pattern_next;
    logic [SUM_W-1:0]    raw_sum, total_sum;
    logic [GAIN_W-1:0]   gain_sat;
    logic                accept, take, arith_idle, arith_done;
    logic [LEVEL_W-1:0]  arith_level, arith_smoothed;

    assign accept = item_valid && item_ready;

    always_comb
    begin
        last_a_next  = item.gate_a_present ? item.gate_a : last_a_reg;
        last_b_next  = item.gate_b_present ? item.gate_b : last_b_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if ((last_a_next && !last_a_reg) || item.advance_a)
        begin
            count_a_next = count_a_reg + 4'd1;
        end
        if ((last_b_next && !last_b_reg) || item.advance_b)
        begin
            count_b_next = count_b_reg + 4'd1;
        end
        pattern_next = count_a_next ^ count_b_next;
    end

    always_comb
    begin
        raw_sum   = '0;
        total_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            total_sum = total_sum + {{(SUM_W-GAIN_W){1'b0}}, gain_reg[i]};
            if (pattern_next[i])
            begin
                raw_sum = raw_sum + {{(SUM_W-GAIN_W){1'b0}}, gain_reg[i]};
            end
        end
    end

    assign gain_sat = (cfg_data[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : cfg_data[GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                gain_reg[i] <= GAIN_RESET;
            end
            coef_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_0: gain_reg[0] <= gain_sat;
                REG_GAIN_1: gain_reg[1] <= gain_sat;
                REG_GAIN_2: gain_reg[2] <= gain_sat;
                REG_GAIN_3: gain_reg[3] <= gain_sat;
                REG_COEF:   coef_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    dcxm_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .raw      (raw_sum),
        .total    (total_sum),
        .alpha    (coef_reg),
        .prev     (smoother_reg),
        .take     (take),
        .idle     (arith_idle),
        .done     (arith_done),
        .level    (arith_level),
        .smoothed (arith_smoothed)
    );

    assign take = arith_done && (!result_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg      <= '0;
            count_b_reg      <= '0;
            last_a_reg       <= 1'b0;
            last_b_reg       <= 1'b0;
            smoother_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_a_reg <= count_a_next;
                count_b_reg <= count_b_next;
                last_a_reg  <= last_a_next;
                last_b_reg  <= last_b_next;
            end
            if (take)
            begin
                smoother_reg     <= arith_smoothed;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pattern_reg <= pattern_next;
        end
        if (take)
        begin
            result_reg.level          <= arith_level;
            result_reg.smoothed_level <= arith_smoothed;
            result_reg.gate_out       <= pattern_reg[0];
            result_reg.gate2_out      <= pattern_reg[1];
            result_reg.pattern        <= pattern_reg;
        end
    end

    assign item_ready   = arith_idle;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/sv/dual_counter_xor_modulator_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for dual_counter_xor_modulator: randomized ticks, gains and stalls.
module dual_counter_xor_modulator_tb;
    import dcxm_pkg::*;

    localparam int unsigned TICKS_PER_PHASE = 150;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned HOLD_PHASE      = 2;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned DRAIN_CYCLES    = 50;
    localparam int unsigned TIMEOUT_NS      = 30_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_word_t            item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_word_t          result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COEF_W-1:0]     cfg_data = '0;

    dual_counter_xor_modulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state, reset values
    logic [GAIN_W-1:0]  gain_tbl [4] = '{GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET};
    logic [COEF_W-1:0]  alpha = '0;
    logic [CNT_W-1:0]   count_a = '0;
    logic [CNT_W-1:0]   count_b = '0;
    logic               prev_gate_a = 1'b0;
    logic               prev_gate_b = 1'b0;
    logic [LEVEL_W-1:0] smoothed = '0;

    item_word_t   ticks_to_send [$];
    result_word_t results_owed [$];
    int unsigned  fail_count = 0;
    int unsigned  idle_pct = 0;
    int unsigned  hold_req = 0;

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        logic [GAIN_W-1:0] g;
        g = data[GAIN_W-1:0];
        case (idx) inside
            REG_GAIN_0, REG_GAIN_1, REG_GAIN_2, REG_GAIN_3:
                gain_tbl[idx[1:0]] = (g > GAIN_MAX) ? GAIN_MAX : g;
            REG_COEF:
                alpha = data;
            default: ;
        endcase
    endfunction

    function automatic result_word_t modulate_tick(item_word_t w);
        logic               g_a;
        logic               g_b;
        logic [CNT_W-1:0]   pat;
        logic [SUM_W-1:0]   total;
        logic [SUM_W-1:0]   raw;
        logic [63:0]        quo;
        logic [63:0]        acc;
        result_word_t       r;
        g_a = w.gate_a_present ? w.gate_a : prev_gate_a;
        if ((g_a && !prev_gate_a) || w.advance_a)
            count_a = count_a + CNT_W'(1);
        prev_gate_a = g_a;
        g_b = w.gate_b_present ? w.gate_b : prev_gate_b;
        if ((g_b && !prev_gate_b) || w.advance_b)
            count_b = count_b + CNT_W'(1);
        prev_gate_b = g_b;
        pat = count_a ^ count_b;
        total = '0;
        raw = '0;
        for (int i = 0; i < 4; i++)
        begin
            total += SUM_W'(gain_tbl[i]);
            if (pat[i])
                raw += SUM_W'(gain_tbl[i]);
        end
        quo = '0;
        if (total != '0)
        begin
            quo = 64'(raw);
            quo = (quo << 16) / 64'(total);
        end
        acc = 64'(alpha) * 64'(smoothed) + (64'd65536 - 64'(alpha)) * quo;
        smoothed = acc[16 +: LEVEL_W];
        r.level = quo[LEVEL_W-1:0];
        r.smoothed_level = smoothed;
        r.gate_out = pat[0];
        r.gate2_out = pat[1];
        r.pattern = pat;
        return r;
    endfunction

    function automatic void check_field(string name, logic [LEVEL_W-1:0] want,
                                        logic [LEVEL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // item driver
    int unsigned src_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                results_owed.push_back(modulate_tick(item));
            if (!item_valid || item_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    item_valid <= 1'b0;
                end
                else if (ticks_to_send.size() != 0)
                begin
                    item <= ticks_to_send.pop_front();
                    item_valid <= 1'b1;
                    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
                        src_gap = $urandom_range(18, 1);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    int unsigned  sink_wait = 0;
    int unsigned  hold_ack = 0;
    result_word_t want;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (results_owed.size() == 0)
                begin
                    $error("result word with nothing expected: %h", result);
                    fail_count++;
                end
                else
                begin
                    want = results_owed.pop_front();
                    check_field("level", want.level, result.level);
                    check_field("smoothed_level", want.smoothed_level, result.smoothed_level);
                    check_field("gate_out", LEVEL_W'(want.gate_out), LEVEL_W'(result.gate_out));
                    check_field("gate2_out", LEVEL_W'(want.gate2_out),
                                LEVEL_W'(result.gate2_out));
                    check_field("pattern", LEVEL_W'(want.pattern), LEVEL_W'(result.pattern));
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                result_ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
            begin
                sink_wait = $urandom_range(18, 1) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (ticks_to_send.size() != 0 || item_valid || results_owed.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_random_ticks(input int unsigned n);
        logic [5:0] bits;
        @(negedge clk);
        repeat (n)
        begin
            bits = 6'($urandom);
            ticks_to_send.push_back(item_word_t'(bits));
        end
    endtask

    task automatic randomize_setup();
        logic [COEF_W-1:0] data;
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(3, 0))
                0: data = '0;
                1: data = 16'(GAIN_MAX);
                2: data = COEF_W'($urandom);
                default: data = COEF_W'($urandom_range(GAIN_MAX, 0));
            endcase
            write_reg(CFG_IDX_W'(REG_GAIN_0 + i), data);
        end
        case ($urandom_range(3, 0))
            0: data = '0;
            1: data = '1;
            default: data = COEF_W'($urandom);
        endcase
        write_reg(REG_COEF, data);
        if ($urandom_range(3, 0) == 0)
            write_reg(CFG_IDX_W'(REG_COEF + 1 + $urandom_range(2, 0)), COEF_W'($urandom));
    endtask

    // fields: gate_a, gate_a_present, advance_a, gate_b, gate_b_present, advance_b
    logic [5:0] directed_ticks [] = '{
        6'b000_000, 6'b110_000, 6'b110_000, 6'b010_000, 6'b100_000,
        6'b111_000, 6'b001_000, 6'b000_110, 6'b000_111, 6'b000_011,
        6'b111_111, 6'b001_000, 6'b001_000, 6'b001_000, 6'b001_000
    };

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // edges, absent gates, forced advances at reset gains
        idle_pct = 20;
        @(negedge clk);
        foreach (directed_ticks[i])
            ticks_to_send.push_back(item_word_t'(directed_ticks[i]));
        wait_drained();

        // zero total gain
        write_reg(REG_GAIN_0, '0);
        write_reg(REG_GAIN_1, '0);
        write_reg(REG_GAIN_2, '0);
        write_reg(REG_GAIN_3, '0);
        push_random_ticks(3);
        wait_drained();

        // saturating and masked gain writes, full retention, ignored indexes
        write_reg(REG_GAIN_0, 16'hFFFF);
        write_reg(REG_GAIN_1, 16'(GAIN_MAX) + 16'd1);
        write_reg(REG_GAIN_2, 16'(GAIN_MAX));
        write_reg(REG_GAIN_3, 16'hF800);
        write_reg(REG_COEF, '1);
        for (int i = REG_COEF + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 16'hFFFF);
        push_random_ticks(4);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_setup();
            @(negedge clk);
            case ($urandom_range(2, 0))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (p == RANDOM_PHASES - 1)
                idle_pct = 0;
            if (p == HOLD_PHASE)
                hold_req++;
            push_random_ticks(TICKS_PER_PHASE);
            wait_drained();
        end

        if (fail_count == 0 && results_owed.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
